// ===== rtl/bts_pkg.sv =====
// Package with shared widths, codes and constants of the bilinear texture sampler.
package bts_pkg;

  localparam int unsigned MaxDimDefault = 256;
  localparam int unsigned DimW          = 9;
  localparam int unsigned CoordW        = 17;
  localparam int unsigned FracW         = 16;
  localparam int unsigned TexelW        = 32;
  localparam int unsigned AddrInW       = 16;
  localparam int unsigned PosW          = CoordW + DimW;
  localparam int unsigned LinW          = 2 * DimW;
  localparam int unsigned WeightW       = 2 * FracW + 1;
  localparam int unsigned ProdW         = WeightW + 8;
  localparam int unsigned SumW          = ProdW + 1;
  localparam int unsigned InDataW       = 88;
  localparam int unsigned CfgIdxW       = 1;

  localparam logic [CoordW-1:0] OneQ16 = CoordW'(65536);

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

endpackage

// ===== rtl/bts_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module bts_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bilinear_texture_sampler.sv =====
// Top level of the bilinear texture sampler: seven-stage pipeline around four texture copies.
// Each beat on the input either stores one texel (tuser low) or samples the texture at u,v
// (tuser high); a sample gives one filtered ARGB beat, a store gives none. The pipeline is
// seven register stages deep, and one beat is taken in every cycle while the output keeps
// up; each stage moves on as soon as the one after it is free. The texture is held in four
// identical RAM copies that every in-range store writes, so the four neighbor texels are read
// together; stores are applied at the read stage, which keeps them in order with the samples
// around them. Texels must be written before they are sampled. Widths of 0 act as 1 and
// widths above MaxDim act as MaxDim.
module bilinear_texture_sampler #(
  parameter int unsigned MaxDim = bts_pkg::MaxDimDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bts_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bts_pkg::DimW-1:0]     cfg_data_i,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // texel_addr[15:0], texel_value[47:16], coord_u[64:48], coord_v[81:65], zeros above.
  input  logic [bts_pkg::InDataW-1:0]  s_axis_tdata_i,
  // op[0].
  input  logic                         s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // color[31:0].
  output logic [bts_pkg::TexelW-1:0]   m_axis_tdata_o
);

  localparam int unsigned MemDepth = MaxDim * MaxDim;
  localparam int unsigned AW       = $clog2(MemDepth);
  localparam int unsigned DimW     = bts_pkg::DimW;
  localparam int unsigned CoordW   = bts_pkg::CoordW;
  localparam int unsigned FracW    = bts_pkg::FracW;
  localparam int unsigned TexelW   = bts_pkg::TexelW;
  localparam int unsigned PosW     = bts_pkg::PosW;
  localparam int unsigned LinW     = bts_pkg::LinW;
  localparam int unsigned WeightW  = bts_pkg::WeightW;
  localparam int unsigned ProdW    = bts_pkg::ProdW;
  localparam int unsigned SumW     = bts_pkg::SumW;
  localparam int unsigned IdxW     = PosW - FracW;

  // Configuration registers.
  logic [DimW-1:0] width_q, height_q;
  logic [DimW-1:0] w_eff, h_eff, w_last, h_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(256);
      height_q <= DimW'(256);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bts_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
        bts_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = width_q;
    if (width_q == '0) begin
      w_eff = DimW'(1);
    end else if (width_q > MaxDim) begin
      w_eff = DimW'(MaxDim);
    end
    h_eff = height_q;
    if (height_q == '0) begin
      h_eff = DimW'(1);
    end else if (height_q > MaxDim) begin
      h_eff = DimW'(MaxDim);
    end
    w_last = w_eff - DimW'(1);
    h_last = h_eff - DimW'(1);
  end

  // Stage valid bits and ready chain.
  logic [6:0] v_q;
  logic [6:0] rdy;

  always_comb begin
    rdy[6] = !v_q[6] || m_axis_tready_i;
    for (int k = 5; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign s_axis_tready_o = rdy[0];

  // Stage payloads.
  bts_pkg::op_e              op0_q, op1_q, op2_q, op3_q;
  logic [bts_pkg::AddrInW-1:0] wa0_q;
  logic [AW-1:0]             wa1_q, wa2_q, wa3_q;
  logic                      wok1_q, wok2_q, wok3_q;
  logic [TexelW-1:0]         wd0_q, wd1_q, wd2_q, wd3_q;
  logic [CoordW-1:0]         u0_q, fv0_q;
  logic [PosW-1:0]           x1_q, y1_q;
  logic [DimW-1:0]           c0_2_q, c1_2_q, r0_2_q, r1_2_q;
  logic [FracW-1:0]          fx2_q, fy2_q;
  logic [AW-1:0]             ra_q [4];
  logic [WeightW-1:0]        wt3_q [4];
  logic [WeightW-1:0]        wt4_q [4];
  logic [TexelW-1:0]         tex4 [4];
  logic [ProdW-1:0]          prod5_q [4][4];
  logic [TexelW-1:0]         color6_q;

  // Stage 0 inputs with coordinate saturation and the v flip.
  logic [CoordW-1:0] u_in, v_in;

  always_comb begin
    u_in = s_axis_tdata_i[64:48];
    v_in = s_axis_tdata_i[81:65];
    if (u_in > bts_pkg::OneQ16) begin
      u_in = bts_pkg::OneQ16;
    end
    if (v_in > bts_pkg::OneQ16) begin
      v_in = bts_pkg::OneQ16;
    end
  end

  // Stage 2 index and clamp logic.
  logic [IdxW:0] ix, iy, ix1, iy1;

  always_comb begin
    ix  = {1'b0, x1_q[PosW-1:FracW]};
    iy  = {1'b0, y1_q[PosW-1:FracW]};
    ix1 = ix + (IdxW+1)'(1);
    iy1 = iy + (IdxW+1)'(1);
  end

  // Stage 3 weights.
  logic [CoordW-1:0] gx, gy;

  assign gx = bts_pkg::OneQ16 - CoordW'(fx2_q);
  assign gy = bts_pkg::OneQ16 - CoordW'(fy2_q);

  // Stage 6 channel sums.
  logic [SumW-1:0] sum6 [4];
  logic [TexelW-1:0] color_d;

  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      sum6[ch] = SumW'(prod5_q[ch][0]) + SumW'(prod5_q[ch][1])
               + SumW'(prod5_q[ch][2]) + SumW'(prod5_q[ch][3]);
      color_d[ch*8 +: 8] = sum6[ch][39:32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= s_axis_tvalid_i;
      for (int k = 1; k < 7; k++) begin
        if (rdy[k]) begin
          if (k == 4) begin
            v_q[k] <= v_q[3] && (op3_q == bts_pkg::OP_SAMPLE);
          end else begin
            v_q[k] <= v_q[k-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      op0_q  <= bts_pkg::op_e'(s_axis_tuser_i);
      wa0_q  <= s_axis_tdata_i[15:0];
      wd0_q  <= s_axis_tdata_i[47:16];
      u0_q   <= u_in;
      fv0_q  <= bts_pkg::OneQ16 - v_in;
    end
    if (rdy[1]) begin
      op1_q  <= op0_q;
      wa1_q  <= AW'(wa0_q);
      wok1_q <= 32'(wa0_q) < 32'(MemDepth);
      wd1_q  <= wd0_q;
      x1_q   <= PosW'(u0_q) * PosW'(w_eff);
      y1_q   <= PosW'(fv0_q) * PosW'(h_eff);
    end
    if (rdy[2]) begin
      op2_q  <= op1_q;
      wa2_q  <= wa1_q;
      wok2_q <= wok1_q;
      wd2_q  <= wd1_q;
      c0_2_q <= (ix  > (IdxW+1)'(w_last)) ? w_last : DimW'(ix);
      c1_2_q <= (ix1 > (IdxW+1)'(w_last)) ? w_last : DimW'(ix1);
      r0_2_q <= (iy  > (IdxW+1)'(h_last)) ? h_last : DimW'(iy);
      r1_2_q <= (iy1 > (IdxW+1)'(h_last)) ? h_last : DimW'(iy1);
      fx2_q  <= x1_q[FracW-1:0];
      fy2_q  <= y1_q[FracW-1:0];
    end
    if (rdy[3]) begin
      op3_q  <= op2_q;
      wa3_q  <= wa2_q;
      wok3_q <= wok2_q;
      wd3_q  <= wd2_q;
      ra_q[0] <= AW'(LinW'(r0_2_q) * LinW'(w_eff) + LinW'(c0_2_q));
      ra_q[1] <= AW'(LinW'(r0_2_q) * LinW'(w_eff) + LinW'(c1_2_q));
      ra_q[2] <= AW'(LinW'(r1_2_q) * LinW'(w_eff) + LinW'(c0_2_q));
      ra_q[3] <= AW'(LinW'(r1_2_q) * LinW'(w_eff) + LinW'(c1_2_q));
      wt3_q[0] <= WeightW'(34'(gx) * 34'(gy));
      wt3_q[1] <= WeightW'(34'(fx2_q) * 34'(gy));
      wt3_q[2] <= WeightW'(34'(gx) * 34'(fy2_q));
      wt3_q[3] <= WeightW'(34'(fx2_q) * 34'(fy2_q));
    end
    if (rdy[4]) begin
      wt4_q <= wt3_q;
    end
    if (rdy[5]) begin
      for (int ch = 0; ch < 4; ch++) begin
        for (int n = 0; n < 4; n++) begin
          prod5_q[ch][n] <= ProdW'(tex4[n][ch*8 +: 8]) * ProdW'(wt4_q[n]);
        end
      end
    end
    if (rdy[6]) begin
      color6_q <= color_d;
    end
  end

  // Texture copies, one per neighbor; stores go to all of them at the read stage.
  logic ram_we;

  assign ram_we = v_q[3] && (op3_q == bts_pkg::OP_WRITE) && wok3_q && rdy[4];

  for (genvar n = 0; n < 4; n++) begin : g_bank
    bts_ram #(
      .Width (TexelW),
      .Depth (MemDepth)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (ram_we),
      .waddr_i (wa3_q),
      .wdata_i (wd3_q),
      .re_i    (rdy[4]),
      .raddr_i (ra_q[n]),
      .rdata_o (tex4[n])
    );
  end

  assign m_axis_tvalid_o = v_q[6];
  assign m_axis_tdata_o  = color6_q;

  a_accept_fills_stage0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> v_q[0])
    else $error("accepted beat did not enter stage 0");

  a_index_clamped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[2] |-> (c0_2_q <= w_last) && (c1_2_q <= w_last)
            && (r0_2_q <= h_last) && (r1_2_q <= h_last))
    else $error("neighbor index beyond texture edge");

  a_weights_sum_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[4] |-> (35'(wt4_q[0]) + 35'(wt4_q[1]) + 35'(wt4_q[2]) + 35'(wt4_q[3]))
               == 35'h1_0000_0000)
    else $error("bilinear weights do not sum to one");

  a_store_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> !v_q[4])
    else $error("texel store produced a result beat");

endmodule

// ===== tb/sv/bilinear_texture_sampler_checker.sv =====
// Checker that predicts the filtered colors of the texture sampler and compares its output beats.
`timescale 1ns / 1ps
module bilinear_texture_sampler_checker
  import bts_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [DimW-1:0]     cfg_data_i,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  // texel_addr[15:0], texel_value[47:16], coord_u[64:48], coord_v[81:65], zeros above.
  input  logic [InDataW-1:0]  s_tdata_i,
  // op[0].
  input  logic                s_tuser_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  // color[31:0].
  input  logic [TexelW-1:0]   m_tdata_i,
  output int                  pending_o,
  output int                  fail_count_o
);

  logic [TexelW-1:0] texture [65536];
  logic [DimW-1:0]   width_reg;
  logic [DimW-1:0]   height_reg;
  logic [TexelW-1:0] color_queue [$];

  function automatic int unsigned eff_dim(logic [DimW-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MaxDimDefault) return MaxDimDefault;
    return raw;
  endfunction

  function automatic logic [TexelW-1:0] filter_color(logic [CoordW-1:0] u_in,
                                                    logic [CoordW-1:0] v_in);
    int unsigned w, h, u, v, x, y, ix, iy, fx, fy, gx, gy, c0, c1, r0, r1;
    logic [TexelW-1:0] ta, tb, tc, td, color;
    longint unsigned wa, wb, wc, wd, acc;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    u = (u_in > 65536) ? 65536 : u_in;
    v = (v_in > 65536) ? 65536 : v_in;
    v = 65536 - v;
    x = u * w;
    y = v * h;
    ix = x >> 16;
    iy = y >> 16;
    fx = x & 16'hFFFF;
    fy = y & 16'hFFFF;
    gx = 65536 - fx;
    gy = 65536 - fy;
    c0 = (ix > w - 1) ? w - 1 : ix;
    c1 = (ix + 1 > w - 1) ? w - 1 : ix + 1;
    r0 = (iy > h - 1) ? h - 1 : iy;
    r1 = (iy + 1 > h - 1) ? h - 1 : iy + 1;
    ta = texture[r0 * w + c0];
    tb = texture[r0 * w + c1];
    tc = texture[r1 * w + c0];
    td = texture[r1 * w + c1];
    wa = longint'(gx) * gy;
    wb = longint'(fx) * gy;
    wc = longint'(gx) * fy;
    wd = longint'(fx) * fy;
    for (int sh = 0; sh < 32; sh += 8) begin
      acc = longint'(ta[sh+:8]) * wa + longint'(tb[sh+:8]) * wb
          + longint'(tc[sh+:8]) * wc + longint'(td[sh+:8]) * wd;
      color[sh+:8] = acc[39:32];
    end
    return color;
  endfunction

  assign pending_o = color_queue.size();

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  <= DimW'(256);
      height_reg <= DimW'(256);
      color_queue.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_e'(cfg_idx_i) == CFG_WIDTH) width_reg <= cfg_data_i;
        else height_reg <= cfg_data_i;
      end
      if (s_tvalid_i && s_tready_i) begin
        if (op_e'(s_tuser_i) == OP_WRITE) begin
          texture[s_tdata_i[15:0]] = s_tdata_i[47:16];
        end else begin
          color_queue.push_back(filter_color(s_tdata_i[64:48], s_tdata_i[81:65]));
        end
      end
      if (m_tvalid_i && m_tready_i) begin
        if (color_queue.size() == 0) begin
          $error("unexpected color beat: actual %h", m_tdata_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          logic [TexelW-1:0] want;
          want = color_queue.pop_front();
          if (want !== m_tdata_i) begin
            $error("color mismatch: expected %h actual %h", want, m_tdata_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/bilinear_texture_sampler_test.sv =====
// Testbench top of the bilinear texture sampler: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module bilinear_texture_sampler_test;
  import bts_pkg::*;

  localparam int NumPhases = 8;
  localparam int CycleLimit = 400000;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  cfg_idx_e            cfg_idx;
  logic [DimW-1:0]     cfg_data;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [TexelW-1:0]   m_tdata;
  int                  pending;
  int                  fail_count;
  int                  idle_pct;
  int                  stall_pct;
  bit                  long_hold_req;
  int                  cycle_count;

  bilinear_texture_sampler u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  bilinear_texture_sampler_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int hold_left;
    hold_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic int unsigned eff_dim(logic [DimW-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MaxDimDefault) return MaxDimDefault;
    return raw;
  endfunction

  task automatic send_beat(op_e op, logic [15:0] addr, logic [31:0] value,
                           logic [CoordW-1:0] u, logic [CoordW-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'b0, v, u, value, addr};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [DimW-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (12) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_sample(logic [CoordW-1:0] u, logic [CoordW-1:0] v);
    send_beat(OP_SAMPLE, 16'($urandom), $urandom, u, v);
  endtask

  function automatic logic [CoordW-1:0] rand_coord();
    case ($urandom_range(9))
      0: return 0;
      1: return CoordW'(65536);
      2: return CoordW'($urandom);
      default: return CoordW'($urandom_range(65536));
    endcase
  endfunction

  logic [DimW-1:0] width_raw  [NumPhases] = '{3, 511, 1, 0, 8, 1, 5, 2};
  logic [DimW-1:0] height_raw [NumPhases] = '{4, 1, 64, 0, 8, 511, 7, 32};

  initial begin
    int area;
    cycle_count   = 0;
    long_hold_req = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    cfg_we   = 1'b0;
    cfg_idx  = CFG_WIDTH;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = OP_WRITE;
    rst_n    = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      write_reg(CFG_WIDTH, width_raw[ph]);
      write_reg(CFG_HEIGHT, height_raw[ph]);
      area = eff_dim(width_raw[ph]) * eff_dim(height_raw[ph]);
      for (int a = 0; a < area; a++) send_beat(OP_WRITE, 16'(a), $urandom, 0, 0);
      if (ph == 0) begin
        send_beat(OP_WRITE, 16'hFFFF, 32'hFFFF_FFFF, '1, '1);
        send_beat(OP_WRITE, 16'h8000, 32'h0000_0000, 0, 0);
      end
      send_sample(0, 0);
      send_sample(CoordW'(65536), CoordW'(65536));
      send_sample(CoordW'(65535), 1);
      send_sample(1, CoordW'(65535));
      send_sample('1, '1);
      send_sample(CoordW'(32768), CoordW'(32768));
      if (ph == 2) long_hold_req = 1'b1;
      for (int i = 0; i < 56; i++) begin
        if ($urandom_range(9) < 7) begin
          send_sample(rand_coord(), rand_coord());
        end else if ($urandom_range(4) == 0) begin
          send_beat(OP_WRITE, 16'($urandom_range(65535, area)), $urandom,
                    CoordW'($urandom), CoordW'($urandom));
        end else begin
          send_beat(OP_WRITE, 16'($urandom_range(area - 1)), $urandom, 0, 0);
        end
      end
      drain();
    end
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== bilinear_texture_sampler.f =====
rtl/bts_pkg.sv
rtl/bts_ram.sv
rtl/bilinear_texture_sampler.sv
tb/sv/bilinear_texture_sampler_checker.sv
tb/sv/bilinear_texture_sampler_test.sv
